// ===== hw/rtl/rbcf_pkg.sv =====
package rbcf_pkg;

   // Input word: one update call
   typedef struct packed {
      logic [31:0] time_ms;
      logic [4:0]  emotion_code;
   } req_word_type;

   // Result word: one pixel frame
   typedef struct packed {
      logic [7:0] red_level;
      logic [7:0] green_level;
      logic [7:0] blue_level;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // CSR indexes
   localparam logic [2:0] CSR_FRAME_INTERVAL = 3'd0;
   localparam logic [2:0] CSR_SMOOTH_GAIN    = 3'd1;
   localparam logic [2:0] CSR_PHASE_STEP     = 3'd2;
   localparam logic [2:0] CSR_BRIGHT_FLOOR   = 3'd3;
   localparam logic [2:0] CSR_BRIGHT_SPAN    = 3'd4;

   // CSR reset values
   localparam logic [15:0] FRAME_INTERVAL_RST = 16'd20;
   localparam logic [15:0] SMOOTH_GAIN_RST    = 16'd3277;
   localparam logic [15:0] PHASE_STEP_RST     = 16'd209;
   localparam logic [7:0]  BRIGHT_FLOOR_RST   = 8'd35;
   localparam logic [7:0]  BRIGHT_SPAN_RST    = 8'd55;

   // Emotion codes
   localparam logic [4:0] EMO_NORMAL      = 5'd0;
   localparam logic [4:0] EMO_HAPPY       = 5'd1;
   localparam logic [4:0] EMO_GLEE        = 5'd2;
   localparam logic [4:0] EMO_AWE         = 5'd3;
   localparam logic [4:0] EMO_SAD         = 5'd4;
   localparam logic [4:0] EMO_WORRIED     = 5'd5;
   localparam logic [4:0] EMO_FOCUSED     = 5'd6;
   localparam logic [4:0] EMO_ANGRY       = 5'd7;
   localparam logic [4:0] EMO_ANNOYED     = 5'd8;
   localparam logic [4:0] EMO_FRUSTRATED  = 5'd9;
   localparam logic [4:0] EMO_FURIOUS     = 5'd10;
   localparam logic [4:0] EMO_SCARED      = 5'd11;
   localparam logic [4:0] EMO_SUSPICIOUS  = 5'd12;
   localparam logic [4:0] EMO_SURPRISED   = 5'd13;
   localparam logic [4:0] EMO_SKEPTIC     = 5'd14;
   localparam logic [4:0] EMO_UNIMPRESSED = 5'd15;
   localparam logic [4:0] EMO_SQUINT      = 5'd16;
   localparam logic [4:0] EMO_SLEEPY      = 5'd17;

   // Half-turn sine approximation: s = 2^17 q / (DIV_BASE - q), q = k(128-k)
   localparam logic [14:0] DIV_BASE   = 15'd20480;
   localparam logic [16:0] HALF_TURN  = 17'd32768;
   localparam logic [7:0]  HALF_INDEX = 8'd128;
   localparam logic [8:0]  LEVEL_MAX  = 9'd255;

   // Target color per emotion; unknown codes fall back to calm green
   function automatic rgb_type palette(input logic [4:0] code);
      rgb_type c;
      case (code) inside
         EMO_HAPPY, EMO_GLEE:                 c = '{8'd255, 8'd180, 8'd60};
         EMO_AWE:                             c = '{8'd180, 8'd160, 8'd255};
         EMO_SAD, EMO_WORRIED:                c = '{8'd60, 8'd80, 8'd140};
         EMO_FOCUSED:                         c = '{8'd80, 8'd140, 8'd120};
         EMO_ANGRY, EMO_ANNOYED,
         EMO_FRUSTRATED, EMO_FURIOUS:         c = '{8'd255, 8'd50, 8'd40};
         EMO_SCARED, EMO_SUSPICIOUS:          c = '{8'd140, 8'd40, 8'd160};
         EMO_SURPRISED:                       c = '{8'd200, 8'd200, 8'd255};
         EMO_SKEPTIC, EMO_UNIMPRESSED,
         EMO_SQUINT:                          c = '{8'd90, 8'd90, 8'd90};
         EMO_SLEEPY:                          c = '{8'd40, 8'd60, 8'd120};
         EMO_NORMAL:                          c = '{8'd40, 8'd120, 8'd60};
         default:                             c = '{8'd40, 8'd120, 8'd60};
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/rgb_breathing_color_fader.sv =====
// Breathing color fader for one RGB pixel.
// Input channel (req_): one word per update call, carrying the current
// millisecond time and an emotion code. The emotion selects a target color.
// If fewer than frame_interval_ms ms have passed since the last frame, the
// word is dropped in the check step and no result follows. Otherwise each
// channel steps toward its target, the breath phase advances, and one result
// word (rsp_) carries the brightness-scaled red, green and blue levels.
// One 16x16 multiplier is shared by the three color steps, the sine term,
// the brightness scale and the three output scalings, and a bit-serial
// divider forms the sine term. req_stall is high while a word is in work,
// so a new word is taken only after the last one has been dropped or its
// frame handed to the output register.
// The result sits in an output register; the next word is taken while it
// waits. If the receiver still stalls when the next frame is done, the
// sequencer holds that frame until the output register frees up.
// CSR writes (csr_) take effect at once; the user must make them while idle,
// as the block does not enforce it. Synchronous reset clears the fade state,
// phase, frame time and CSRs to defaults; no result is pending after reset.
module rgb_breathing_color_fader (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rbcf_pkg::req_word_type      req_word,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rbcf_pkg::rsp_word_type      rsp_word,
   input  logic                        csr_we,
   input  logic [2:0]                  csr_index,
   input  logic [15:0]                 csr_wdata
);
   import rbcf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_DIST, S_AMUL, S_AUPD, S_QMUL, S_DINIT, S_DIV,
      S_BREATH, S_BMUL, S_SCALE, S_OMUL, S_ODIV, S_EMIT
   } state_type;

   state_type    state_ff, state_in;
   logic [15:0]  interval_ff, interval_in;
   logic [15:0]  gain_ff, gain_in;
   logic [15:0]  step_ff, step_in;
   logic [7:0]   floor_ff, floor_in;
   logic [7:0]   span_ff, span_in;
   logic [31:0]  last_ff, last_in;
   logic [31:0]  now_ff, now_in;
   logic [15:0]  cur_ff [3];
   logic [15:0]  cur_in [3];
   logic [7:0]   tgt_ff [3];
   logic [7:0]   tgt_in [3];
   logic [7:0]   lvl_ff [3];
   logic [7:0]   lvl_in [3];
   logic [15:0]  phase_ff, phase_in;
   logic [1:0]   ch_ff, ch_in;
   logic [15:0]  dist_ff, dist_in;
   logic         up_ff, up_in;
   logic [31:0]  prod_ff, prod_in;
   logic [14:0]  den_ff, den_in;
   logic [15:0]  rem_ff, rem_in;
   logic [15:0]  quo_ff, quo_in;
   logic [3:0]   cnt_ff, cnt_in;
   logic [15:0]  breath_ff, breath_in;
   logic [7:0]   scale_ff, scale_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // Shared multiplier operands
   logic [15:0]  mul_a, mul_b;

   // Per-step datapath terms
   rgb_type      pal;
   logic [31:0]  elapsed;
   logic [15:0]  tgt16;
   logic [15:0]  cur_sel;
   logic [15:0]  move;
   logic [6:0]   sine_k;
   logic [15:0]  rem_sh;
   logic [16:0]  sum17;
   logic [16:0]  diff17;
   logic [8:0]   scale_sum;
   logic [15:0]  div_y;
   logic [7:0]   div_qe;
   logic [8:0]   div_r;
   logic [7:0]   level;

   assign pal       = palette(req_word.emotion_code);
   assign elapsed   = now_ff - last_ff;
   assign cur_sel   = cur_ff[ch_ff];
   assign tgt16     = {tgt_ff[ch_ff], 8'd0};
   assign move      = prod_ff[31:16];
   assign sine_k    = phase_ff[14:8];
   assign rem_sh    = {rem_ff[14:0], 1'b0};
   assign sum17     = HALF_TURN + {1'b0, quo_ff};
   assign diff17    = HALF_TURN - {1'b0, quo_ff};
   assign scale_sum = {1'b0, floor_ff} + {1'b0, prod_ff[23:16]};
   // divide by 65280: drop 8 bits, then divide by 255 with one correction
   assign div_y     = prod_ff[23:8];
   assign div_qe    = div_y[15:8];
   assign div_r     = {1'b0, div_y[7:0]} + {1'b0, div_qe};
   assign level     = div_qe + ((div_r >= LEVEL_MAX) ? 8'd1 : 8'd0);

   assign prod_in   = mul_a * mul_b;

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      gain_in      = gain_ff;
      step_in      = step_ff;
      floor_in     = floor_ff;
      span_in      = span_ff;
      last_in      = last_ff;
      now_in       = now_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      lvl_in       = lvl_ff;
      phase_in     = phase_ff;
      ch_in        = ch_ff;
      dist_in      = dist_ff;
      up_in        = up_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      breath_in    = breath_ff;
      scale_in     = scale_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      mul_a        = '0;
      mul_b        = '0;

      // result word taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // CSR writes; unknown indexes ignored
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_INTERVAL: interval_in = csr_wdata;
            CSR_SMOOTH_GAIN:    gain_in     = csr_wdata;
            CSR_PHASE_STEP:     step_in     = csr_wdata;
            CSR_BRIGHT_FLOOR:   floor_in    = csr_wdata[7:0];
            CSR_BRIGHT_SPAN:    span_in     = csr_wdata[7:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in    = req_word.time_ms;
               tgt_in[0] = pal.red;
               tgt_in[1] = pal.green;
               tgt_in[2] = pal.blue;
               state_in  = S_CHECK;
            end
         end
         // frame gate
         S_CHECK: begin
            if (elapsed < {16'd0, interval_ff}) begin
               state_in = S_IDLE;
            end else begin
               last_in  = now_ff;
               phase_in = phase_ff + step_ff;
               ch_in    = 2'd0;
               state_in = S_DIST;
            end
         end
         // color approach: distance, times gain, step
         S_DIST: begin
            if (tgt16 >= cur_sel) begin
               dist_in = tgt16 - cur_sel;
               up_in   = 1'b1;
            end else begin
               dist_in = cur_sel - tgt16;
               up_in   = 1'b0;
            end
            state_in = S_AMUL;
         end
         S_AMUL: begin
            mul_a    = dist_ff;
            mul_b    = gain_ff;
            state_in = S_AUPD;
         end
         S_AUPD: begin
            cur_in[ch_ff] = up_ff ? (cur_sel + move) : (cur_sel - move);
            if (ch_ff == 2'd2) begin
               state_in = S_QMUL;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = S_DIST;
            end
         end
         // sine term: q = k * (128 - k)
         S_QMUL: begin
            mul_a    = {9'd0, sine_k};
            mul_b    = {8'd0, HALF_INDEX - {1'b0, sine_k}};
            state_in = S_DINIT;
         end
         S_DINIT: begin
            den_in   = DIV_BASE - {2'd0, prod_ff[12:0]};
            rem_in   = {2'd0, prod_ff[12:0], 1'b0};
            quo_in   = '0;
            cnt_in   = 4'd15;
            state_in = S_DIV;
         end
         // restoring divide, one quotient bit a cycle
         S_DIV: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = rem_sh - {1'b0, den_ff};
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[14:0], 1'b0};
            end
            if (cnt_ff == 4'd0) begin
               state_in = S_BREATH;
            end else begin
               cnt_in = cnt_ff - 4'd1;
            end
         end
         S_BREATH: begin
            if (phase_ff[15]) begin
               breath_in = diff17[15:0];
            end else begin
               breath_in = sum17[16] ? 16'hFFFF : sum17[15:0];
            end
            state_in = S_BMUL;
         end
         S_BMUL: begin
            mul_a    = breath_ff;
            mul_b    = {8'd0, span_ff};
            state_in = S_SCALE;
         end
         S_SCALE: begin
            scale_in = scale_sum[8] ? 8'hFF : scale_sum[7:0];
            ch_in    = 2'd0;
            state_in = S_OMUL;
         end
         // output levels: cur * scale / 65280
         S_OMUL: begin
            mul_a    = cur_sel;
            mul_b    = {8'd0, scale_ff};
            state_in = S_ODIV;
         end
         S_ODIV: begin
            lvl_in[ch_ff] = level;
            if (ch_ff == 2'd2) begin
               state_in = S_EMIT;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = S_OMUL;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_word_in.red_level   = lvl_ff[0];
               rsp_word_in.green_level = lvl_ff[1];
               rsp_word_in.blue_level  = lvl_ff[2];
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         interval_ff  <= FRAME_INTERVAL_RST;
         gain_ff      <= SMOOTH_GAIN_RST;
         step_ff      <= PHASE_STEP_RST;
         floor_ff     <= BRIGHT_FLOOR_RST;
         span_ff      <= BRIGHT_SPAN_RST;
         last_ff      <= '0;
         cur_ff       <= '{default: '0};
         phase_ff     <= '0;
         ch_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         gain_ff      <= gain_in;
         step_ff      <= step_in;
         floor_ff     <= floor_in;
         span_ff      <= span_in;
         last_ff      <= last_in;
         cur_ff       <= cur_in;
         phase_ff     <= phase_in;
         ch_ff        <= ch_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      tgt_ff      <= tgt_in;
      lvl_ff      <= lvl_in;
      dist_ff     <= dist_in;
      up_ff       <= up_in;
      prod_ff     <= prod_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      breath_ff   <= breath_in;
      scale_ff    <= scale_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Divider remainder stays below the divisor
   a_div_rem : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < {1'b0, den_ff}))
      else $error("divider remainder out of range");

   // Sine magnitude never exceeds a half turn
   a_sine_max : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BREATH) |-> (quo_ff <= HALF_TURN[15:0]))
      else $error("sine term above half turn");

   // Faded colors never pass the largest target
   a_cur_range : assert property (@(posedge clock) disable iff (reset)
      (cur_ff[0] <= 16'hFF00) && (cur_ff[1] <= 16'hFF00) && (cur_ff[2] <= 16'hFF00))
      else $error("color channel beyond target range");

   // A new result only follows the emit step
   a_emit : assert property (@(posedge clock) disable iff (reset)
      (!$past(rsp_valid_ff) && rsp_valid_ff) |-> ($past(state_ff) == S_EMIT))
      else $error("result word without emit");

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
   import rbcf_pkg::*;

   localparam int          SINE_N        = 256;
   localparam logic [63:0] HALF_T        = 64'd32768;
   localparam int          SETTLE_CYCLES = 60;
   localparam int          STUCK_LIMIT   = 2000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         csr_we    = 1'b0;
   logic [2:0]   csr_index = CSR_FRAME_INTERVAL;
   logic [15:0]  csr_wdata = '0;

   rgb_breathing_color_fader u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Shadow registers and fade state of the pixel
   logic [15:0]  ivl_ms, gain_q16, step_q16;
   logic [7:0]   floor_lvl, span_lvl;
   logic [31:0]  last_frame_ms;
   logic [15:0]  fade_q8 [3];
   logic [15:0]  phase_acc;
   rsp_word_type frames_due [$];
   rsp_word_type due_frame;
   int           mismatch_count = 0;
   int           stuck_cycles   = 0;
   int           hold_left      = 0;
   bit           idle_on        = 1'b1;

   // Target color per emotion; anything past sleepy falls back to calm green
   function automatic rgb_type target_of(input logic [4:0] code);
      rgb_type c;
      case (code)
         EMO_HAPPY, EMO_GLEE:                c = '{8'd255, 8'd180, 8'd60};
         EMO_AWE:                            c = '{8'd180, 8'd160, 8'd255};
         EMO_SAD, EMO_WORRIED:               c = '{8'd60, 8'd80, 8'd140};
         EMO_FOCUSED:                        c = '{8'd80, 8'd140, 8'd120};
         EMO_ANGRY, EMO_ANNOYED,
         EMO_FRUSTRATED, EMO_FURIOUS:        c = '{8'd255, 8'd50, 8'd40};
         EMO_SCARED, EMO_SUSPICIOUS:         c = '{8'd140, 8'd40, 8'd160};
         EMO_SURPRISED:                      c = '{8'd200, 8'd200, 8'd255};
         EMO_SKEPTIC, EMO_UNIMPRESSED,
         EMO_SQUINT:                         c = '{8'd90, 8'd90, 8'd90};
         EMO_SLEEPY:                         c = '{8'd40, 8'd60, 8'd120};
         default:                            c = '{8'd40, 8'd120, 8'd60};
      endcase
      return c;
   endfunction

   // Runs one update call on the shadow state; returns 1 when a frame is due
   function automatic bit advance_fade(input req_word_type w, output rsp_word_type frame);
      rgb_type     tgt;
      logic [7:0]  goal [3];
      logic [15:0] goal_q8;
      logic [31:0] elapsed;
      logic [63:0] delta, ang, h, p, s, breath, scale;
      logic [63:0] lvl [3];
      int          c;
      frame   = '0;
      tgt     = target_of(w.emotion_code);
      elapsed = w.time_ms - last_frame_ms;
      if (elapsed < {16'd0, ivl_ms})
         return 1'b0;
      last_frame_ms = w.time_ms;

      // each channel closes a gain fraction of its gap, truncated toward zero
      goal[0] = tgt.red;
      goal[1] = tgt.green;
      goal[2] = tgt.blue;
      for (c = 0; c < 3; c++) begin
         goal_q8 = {goal[c], 8'h00};
         if (goal_q8 >= fade_q8[c]) begin
            delta      = 64'(goal_q8 - fade_q8[c]);
            fade_q8[c] = fade_q8[c] + 16'((delta * gain_q16) >> 16);
         end else begin
            delta      = 64'(fade_q8[c] - goal_q8);
            fade_q8[c] = fade_q8[c] - 16'((delta * gain_q16) >> 16);
         end
      end

      // breath phase, table angle, rational sine per half turn
      phase_acc = phase_acc + step_q16;
      ang    = (((64'(phase_acc) * SINE_N) >> 16) * 65536 / SINE_N) & 64'hFFFF;
      h      = ang & (HALF_T - 1);
      p      = h * (HALF_T - h);
      s      = (16 * p * HALF_T) / (5 * HALF_T * HALF_T - 4 * p);
      breath = ((ang & HALF_T) == 0) ? HALF_T + s : HALF_T - s;
      if (breath > 64'd65535)
         breath = 64'd65535;
      scale = floor_lvl + ((breath * span_lvl) >> 16);
      if (scale > 64'd255)
         scale = 64'd255;

      for (c = 0; c < 3; c++)
         lvl[c] = (64'(fade_q8[c]) * scale) / 64'd65280;
      frame.red_level   = lvl[0][7:0];
      frame.green_level = lvl[1][7:0];
      frame.blue_level  = lvl[2][7:0];
      return 1'b1;
   endfunction

   // Offer one word, wait for the handshake, then predict its frame
   task automatic send_word(input logic [31:0] now_ms, input logic [4:0] code);
      rsp_word_type f;
      int           gap;
      gap = 0;
      if (idle_on && $urandom_range(99) < 27)
         gap = ($urandom_range(9) == 0) ? $urandom_range(13, 50) : $urandom_range(1, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{time_ms: now_ms, emotion_code: code};
      do @(posedge clock); while (req_stall);
      if (advance_fade(req_word, f))
         frames_due.push_back(f);
   endtask

   // Hold off until every predicted frame is out and the block is quiet
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all registers plus one random index beyond the last; only while idle
   task automatic program_regs(input logic [15:0] ivl, gain, step,
                               input logic [7:0] flr, spn);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FRAME_INTERVAL;
      csr_wdata <= ivl;
      @(negedge clock);
      csr_index <= CSR_SMOOTH_GAIN;
      csr_wdata <= gain;
      @(negedge clock);
      csr_index <= CSR_PHASE_STEP;
      csr_wdata <= step;
      // upper byte is junk on the 8-bit registers
      @(negedge clock);
      csr_index <= CSR_BRIGHT_FLOOR;
      csr_wdata <= {8'($urandom), flr};
      @(negedge clock);
      csr_index <= CSR_BRIGHT_SPAN;
      csr_wdata <= {8'($urandom), spn};
      // unmapped index, must be dropped
      @(negedge clock);
      csr_index <= CSR_BRIGHT_SPAN + 3'(1 + $urandom_range(2));
      csr_wdata <= 16'($urandom);
      @(negedge clock);
      csr_we    <= 1'b0;
      ivl_ms    = ivl;
      gain_q16  = gain;
      step_q16  = step;
      floor_lvl = flr;
      span_lvl  = spn;
   endtask

   // Mostly on-time calls with sticky emotions, plus early, jumping and backward times
   task automatic run_random(input int n);
      logic [31:0] t;
      logic [4:0]  code;
      int          pick;
      t    = last_frame_ms;
      code = EMO_NORMAL;
      repeat (n) begin
         if ($urandom_range(99) < 30)
            code = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(EMO_SLEEPY));
         pick = $urandom_range(99);
         if (pick < 65)
            t = t + ivl_ms + $urandom_range(3);
         else if (pick < 85)
            t = t + $urandom_range(ivl_ms);
         else if (pick < 93)
            t = $urandom();
         else
            t = t - $urandom_range(40);
         send_word(t, code);
      end
   endtask

   // Reset register values, every emotion, unknown codes, timer wrap
   task automatic test_directed();
      int i;
      send_word(32'd0, EMO_NORMAL);     // too early right after reset
      send_word(32'd19, EMO_HAPPY);     // one ms short of the interval
      for (i = 0; i <= EMO_SLEEPY; i++)
         send_word(32'(20 * (i + 1)), 5'(i));
      send_word(32'd380, EMO_SLEEPY + 5'd1);
      send_word(32'd400, '1);
      send_word(32'hFFFF_FFF0, EMO_AWE);
      send_word(32'd4, EMO_AWE);        // timer wrapped, exactly one interval on
      send_word(32'd3, EMO_SURPRISED);  // time stepped back reads as a long wait
      settle();
   endtask

   task automatic test_no_idle();
      idle_on = 1'b0;
      run_random(200);
      settle();
      idle_on = 1'b1;
   endtask

   task automatic test_register_extremes();
      // zero interval, full gain and step, brightness past full scale
      program_regs(16'd0, '1, '1, '1, '1);
      run_random(150);
      settle();
      // frozen colors and phase, dark output
      program_regs(16'd1, 16'd0, 16'd0, 8'd0, 8'd0);
      run_random(150);
      settle();
      // longest interval, half-turn phase step
      program_regs('1, 16'd1, 16'd32768, 8'd0, '1);
      run_random(150);
      settle();
   endtask

   task automatic test_pause_for_results();
      run_random(100);
      settle();
      run_random(100);
      settle();
   endtask

   task automatic test_random_settings();
      logic [15:0] ivl;
      repeat (6) begin
         ivl = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 64));
         program_regs(ivl, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
         run_random(150);
         settle();
      end
   endtask

   // Receiver stalls: short random ones, now and then a long hold
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(999) == 0) begin
         hold_left <= $urandom_range(40, 80);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < 23);
      end
   end

   // Compare each accepted result word with the oldest predicted frame
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frames_due.size() == 0) begin
            $display("%0t: frame with none predicted: r=%0d g=%0d b=%0d", $time,
                     rsp_word.red_level, rsp_word.green_level, rsp_word.blue_level);
            mismatch_count++;
         end else begin
            due_frame = frames_due.pop_front();
            if (rsp_word.red_level !== due_frame.red_level) begin
               $display("%0t: red expected %0d got %0d", $time,
                        due_frame.red_level, rsp_word.red_level);
               mismatch_count++;
            end
            if (rsp_word.green_level !== due_frame.green_level) begin
               $display("%0t: green expected %0d got %0d", $time,
                        due_frame.green_level, rsp_word.green_level);
               mismatch_count++;
            end
            if (rsp_word.blue_level !== due_frame.blue_level) begin
               $display("%0t: blue expected %0d got %0d", $time,
                        due_frame.blue_level, rsp_word.blue_level);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: too long without a handshake on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, stuck_cycles);
         $display("rgb_breathing_color_fader test failed");
         $finish;
      end
   end

   initial begin
      ivl_ms        = FRAME_INTERVAL_RST;
      gain_q16      = SMOOTH_GAIN_RST;
      step_q16      = PHASE_STEP_RST;
      floor_lvl     = BRIGHT_FLOOR_RST;
      span_lvl      = BRIGHT_SPAN_RST;
      last_frame_ms = '0;
      phase_acc     = '0;
      fade_q8       = '{default: '0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_no_idle();
      test_register_extremes();
      test_pause_for_results();
      test_random_settings();
      settle();

      if (mismatch_count == 0 && frames_due.size() == 0)
         $display("rgb_breathing_color_fader test passed");
      else
         $display("rgb_breathing_color_fader test failed");
      $finish;
   end

endmodule
